/* rtl/core/ose_pkg.sv */
// Package for the ordered set engine: capacity, derived widths, action codes,
// FSM states and the structs passed between the controller and the cell row.
// No dependencies.
package ose_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_TEST   = 2'd2,
        ACT_SPARE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_SCAN,
        S_EMIT
    } t_state;

    // Per-cell write controls.
    typedef struct packed {
        logic load;   // take the search key
        logic shift;  // take the upper neighbor's value
    } t_cell_op;

    // Running min/max handed from cell to cell.
    typedef struct packed {
        logic                     any;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } t_scan;

endpackage

/* rtl/core/ose_cell.sv */
// One storage cell of the ordered set row: holds one element, compares it to
// the search key and folds it into the min/max scan passed down the row.
// Depends on ose_pkg.
module ose_cell
    import ose_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [DATA_W-1:0] i_key,
    input  t_cell_op                 i_op,
    input  logic signed [DATA_W-1:0] i_next_value,
    input  t_scan                    i_scan,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_match,
    output t_scan                    o_scan
);

    logic signed [DATA_W-1:0] r_value;
    t_scan                    r_scan;
    t_scan                    n_scan;

    always_ff @(posedge i_clk) begin
        if (i_op.load) begin
            r_value <= i_key;
        end else if (i_op.shift) begin
            r_value <= i_next_value;
        end
    end

    // Fold this cell into the running min/max when it holds an element.
    always_comb begin
        n_scan = i_scan;
        if (i_valid) begin
            if (!i_scan.any) begin
                n_scan.any = 1'b1;
                n_scan.lo  = r_value;
                n_scan.hi  = r_value;
            end else begin
                if (r_value < i_scan.lo) begin
                    n_scan.lo = r_value;
                end
                if (r_value > i_scan.hi) begin
                    n_scan.hi = r_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.any <= 1'b0;
        end else begin
            r_scan.any <= n_scan.any;
        end
        r_scan.lo <= n_scan.lo;
        r_scan.hi <= n_scan.hi;
    end

    assign o_value = r_value;
    assign o_match = i_valid && (r_value == i_key);
    assign o_scan  = r_scan;

endmodule

/* rtl/core/ordered_set_engine.sv */
// Ordered set engine top level: command FSM, element count and the row of
// ose_cell instances. Depends on ose_pkg and ose_cell.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  command  | start in, busy out      | i_action, i_value
//  result   | o_valid strobe, 1 cycle | o_was_member, o_changed, o_full_refused,
//           |                         | o_count, o_is_empty, o_min_value,
//           |                         | o_max_value
//
// A transaction runs from start through S_APPLY, where every cell compares in
// parallel and inserts or shifts, and S_SCAN, while the min/max scan ripples
// through the cell row, to S_EMIT with o_valid high for one cycle, then back to
// S_IDLE, in which the next start is taken.
// busy is high from the cycle after start until the result cycle ends. Synchronous
// reset empties the set; cell contents are not cleared. The result is shown for
// one cycle only and cannot be held off.
module ordered_set_engine
    import ose_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_action,
    input  logic signed [DATA_W-1:0]  i_value,
    output logic                      o_valid,
    output logic                      o_was_member,
    output logic                      o_changed,
    output logic                      o_full_refused,
    output logic [COUNT_W-1:0]        o_count,
    output logic                      o_is_empty,
    output logic signed [DATA_W-1:0]  o_min_value,
    output logic signed [DATA_W-1:0]  o_max_value
);

    t_state                   r_state, n_state;
    logic [1:0]               r_action;
    logic signed [DATA_W-1:0] r_key;
    logic [CNT_W-1:0]         r_held, n_held;
    logic [IDX_W-1:0]         r_cnt, n_cnt;
    logic                     r_was_member, n_was_member;
    logic                     r_changed, n_changed;
    logic                     r_refused, n_refused;

    logic [CAPACITY-1:0]      cell_valid;
    logic [CAPACITY-1:0]      cell_match;
    logic [CAPACITY-1:0]      seen_match;
    t_cell_op                 cell_op    [CAPACITY];
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    t_scan                    scan_chain [CAPACITY+1];
    logic                     member;
    logic                     do_insert;
    logic                     do_remove;

    assign member = |cell_match;

    // Cell i shifts on remove when the match sits at or below it.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_valid[i] = CNT_W'(i) < r_held;
            seen_match[i] = |(cell_match & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
        end
    end

    assign scan_chain[0] = '{any: 1'b0, lo: '0, hi: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] next_value;
        if (g == CAPACITY - 1) begin : g_last
            assign next_value = cell_value[g];
        end else begin : g_mid
            assign next_value = cell_value[g+1];
        end

        ose_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (cell_valid[g]),
            .i_key        (r_key),
            .i_op         (cell_op[g]),
            .i_next_value (next_value),
            .i_scan       (scan_chain[g]),
            .o_value      (cell_value[g]),
            .o_match      (cell_match[g]),
            .o_scan       (scan_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_action <= i_action;
            r_key    <= i_value;
        end
        r_was_member <= n_was_member;
        r_changed    <= n_changed;
        r_refused    <= n_refused;
    end

    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_cnt        = r_cnt;
        n_was_member = r_was_member;
        n_changed    = r_changed;
        n_refused    = r_refused;
        do_insert    = 1'b0;
        do_remove    = 1'b0;
        busy         = 1'b1;
        o_valid      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_was_member = member;
                n_changed    = 1'b0;
                n_refused    = 1'b0;
                case (r_action)
                    ACT_INSERT: begin
                        if (!member) begin
                            if (r_held >= CNT_W'(CAPACITY)) begin
                                n_refused = 1'b1;
                            end else begin
                                do_insert = 1'b1;
                                n_changed = 1'b1;
                                n_held    = r_held + CNT_W'(1);
                            end
                        end
                    end
                    ACT_REMOVE: begin
                        if (member) begin
                            do_remove = 1'b1;
                            n_changed = 1'b1;
                            n_held    = r_held - CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                n_cnt   = IDX_W'(CAPACITY - 1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // Hold until the scan has crossed every cell.
                if (r_cnt == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt - IDX_W'(1);
                end
            end
            S_EMIT: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_op[i].load  = do_insert && (CNT_W'(i) == r_held);
            cell_op[i].shift = do_remove && seen_match[i];
        end
    end

    assign o_was_member   = r_was_member;
    assign o_changed      = r_changed;
    assign o_full_refused = r_refused;
    assign o_count        = COUNT_W'(r_held);
    assign o_is_empty     = (r_held == '0);
    assign o_min_value    = scan_chain[CAPACITY].lo;
    assign o_max_value    = scan_chain[CAPACITY].hi;

endmodule

/* rtl/core/ose_checker.sv */
// Port-level checks for the ordered set engine, bound to the top level.
// Depends on ose_pkg and ordered_set_engine.
module ose_checker
    import ose_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_valid,
    input logic                     o_was_member,
    input logic                     o_changed,
    input logic                     o_full_refused,
    input logic [COUNT_W-1:0]       o_count,
    input logic                     o_is_empty,
    input logic signed [DATA_W-1:0] o_min_value,
    input logic signed [DATA_W-1:0] o_max_value
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_min_value == '0 && o_max_value == '0))
        else $error("min or max nonzero on an empty set");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_full_refused) |-> (!o_changed && !o_was_member &&
                                         o_count == COUNT_W'(CAPACITY)))
        else $error("refused insert with inconsistent flags");

endmodule

bind ordered_set_engine ose_checker u_ose_checker (.*);
